>>> hdl/topic_filter_matcher_core_defines.svh
// Assertion macros used by the topic filter matcher top level.
`ifndef TOPIC_FILTER_MATCHER_CORE_DEFINES_SVH
`define TOPIC_FILTER_MATCHER_CORE_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define TFM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define TFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tfm_pkg.sv
// Package with shared types, constants and helpers of the topic filter matcher.
`timescale 1ns / 1ps

package tfm_pkg;

    localparam int PATTERN_BYTES_DEF = 48;
    localparam int WORD_BYTES        = 8;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_ADDR_W        = 6;
    localparam int REG_IDX_W         = 3;
    localparam int POS_W             = 6;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [REG_IDX_W-1:0] REG_LENGTH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WORD0  = 3'd1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // One topic byte after classification.
    typedef struct packed {
        logic [7:0] chr;
        logic       term;
        logic       slash;
    } tfm_item_t;

    // Pattern store status seen by the matching engine.
    typedef struct packed {
        logic             busy;
        logic [POS_W-1:0] eff_len;
    } tfm_cfg_status_t;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_READ,
        SCAN_CHECK
    } tfm_scan_state_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_READ,
        BACK_EXEC
    } tfm_back_state_t;

    function automatic logic [7:0] word_byte(input logic [CFG_DATA_W-1:0] w,
                                             input logic [2:0] sel);
        return w[8*sel +: 8];
    endfunction

endpackage

>>> hdl/tfm_cfg.sv
// Register port, pattern memory and effective-length scanner.
`timescale 1ns / 1ps

module tfm_cfg #(
    parameter int PATTERN_BYTES = tfm_pkg::PATTERN_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tfm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [tfm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [tfm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic [tfm_pkg::REG_IDX_W-1:0]   back_addr,
    output logic [tfm_pkg::CFG_DATA_W-1:0]  rd_data,
    output tfm_pkg::tfm_cfg_status_t        status
);

    localparam int WORDS = (PATTERN_BYTES + tfm_pkg::WORD_BYTES - 1) / tfm_pkg::WORD_BYTES;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = tfm_pkg::POS_W;
    localparam int IW    = tfm_pkg::REG_IDX_W;

    logic [tfm_pkg::CFG_DATA_W-1:0] mem [WORDS];
    logic [WORDS-1:0]               mem_valid_reg;

    logic [PW-1:0]                  length_reg;
    logic [PW-1:0]                  eff_len_reg, eff_len_next;
    logic [IW-1:0]                  word_reg, word_next;
    tfm_pkg::tfm_scan_state_t       state_reg, state_next;

    logic                           rda_len_reg;
    logic                           rda_hit_reg;
    logic [tfm_pkg::CFG_DATA_W-1:0] rda_data_reg;
    logic                           rdb_hit_reg;
    logic [tfm_pkg::CFG_DATA_W-1:0] rdb_data_reg;

    logic                           wr_en;
    logic [IW-1:0]                  reg_idx;
    logic [IW-1:0]                  word_idx;
    logic                           word_hit;
    logic [IW-1:0]                  rdb_addr;
    logic                           rdb_in_range;
    logic [PW-1:0]                  lim;
    logic                           found;
    logic [PW-1:0]                  found_pos;
    logic                           last_word;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign reg_idx  = paddr[tfm_pkg::CFG_ADDR_W-1:3];
    assign word_idx = reg_idx - tfm_pkg::REG_WORD0;
    assign word_hit = (reg_idx != tfm_pkg::REG_LENGTH) && (32'(word_idx) < WORDS);

    // Port B serves the scanner while it runs, the matching engine otherwise.
    assign rdb_addr     = (state_reg != tfm_pkg::SCAN_IDLE) ? word_reg : back_addr;
    assign rdb_in_range = 32'(rdb_addr) < WORDS;

    always_ff @(posedge clk)
    begin
        if (wr_en && word_hit)
        begin
            mem[word_idx[WA-1:0]] <= pwdata;
        end
        rda_data_reg <= mem[word_idx[WA-1:0]];
        rdb_data_reg <= mem[rdb_addr[WA-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= '0;
            length_reg    <= '0;
            eff_len_reg   <= '0;
            word_reg      <= '0;
            state_reg     <= tfm_pkg::SCAN_IDLE;
            rda_len_reg   <= 1'b0;
            rda_hit_reg   <= 1'b0;
            rdb_hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en && word_hit)
            begin
                mem_valid_reg[word_idx[WA-1:0]] <= 1'b1;
            end
            if (wr_en && reg_idx == tfm_pkg::REG_LENGTH)
            begin
                length_reg <= pwdata[PW-1:0];
            end
            // Capture read selection in the setup cycle.
            if (psel && !penable)
            begin
                rda_len_reg <= reg_idx == tfm_pkg::REG_LENGTH;
                rda_hit_reg <= word_hit && mem_valid_reg[word_idx[WA-1:0]];
            end
            rdb_hit_reg <= rdb_in_range && mem_valid_reg[rdb_addr[WA-1:0]];
            eff_len_reg <= eff_len_next;
            word_reg    <= word_next;
            state_reg   <= state_next;
        end
    end

    assign prdata  = rda_len_reg ? {{(tfm_pkg::CFG_DATA_W-PW){1'b0}}, length_reg}
                   : (rda_hit_reg ? rda_data_reg : '0);
    assign rd_data = rdb_hit_reg ? rdb_data_reg : '0;

    assign lim = (32'(length_reg) > PATTERN_BYTES) ? PW'(PATTERN_BYTES) : length_reg;

    // First byte of the fetched word at or beyond the limit, or holding zero.
    always_comb
    begin
        logic [PW-1:0] idx;
        found     = 1'b0;
        found_pos = '0;
        for (int j = tfm_pkg::WORD_BYTES - 1; j >= 0; j--)
        begin
            idx = {word_reg, 3'(j)};
            if (idx >= lim || tfm_pkg::word_byte(rd_data, 3'(j)) == tfm_pkg::CH_NUL)
            begin
                found     = 1'b1;
                found_pos = idx;
            end
        end
    end

    assign last_word = 32'(word_reg) == WORDS - 1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tfm_pkg::SCAN_IDLE:
            begin
                if (wr_en)
                    state_next = tfm_pkg::SCAN_READ;
            end
            tfm_pkg::SCAN_READ:
            begin
                if (!wr_en)
                    state_next = tfm_pkg::SCAN_CHECK;
            end
            tfm_pkg::SCAN_CHECK:
            begin
                if (wr_en)
                    state_next = tfm_pkg::SCAN_READ;
                else if (found || last_word)
                    state_next = tfm_pkg::SCAN_IDLE;
                else
                    state_next = tfm_pkg::SCAN_READ;
            end
            default:
                state_next = tfm_pkg::SCAN_IDLE;
        endcase
    end

    always_comb
    begin
        word_next    = word_reg;
        eff_len_next = eff_len_reg;
        case (state_reg)
            tfm_pkg::SCAN_CHECK:
            begin
                if (found)
                    eff_len_next = found_pos;
                else if (last_word)
                    eff_len_next = lim;
                else
                    word_next = word_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        if (wr_en)
            word_next = '0;
    end

    assign status.busy    = state_reg != tfm_pkg::SCAN_IDLE;
    assign status.eff_len = eff_len_reg;

endmodule

>>> hdl/tfm_front.sv
// Input stage: accept topic bytes, classify them and queue them for matching.
`timescale 1ns / 1ps

module tfm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] topic_char
    input  logic                 hold,
    output tfm_pkg::tfm_item_t   item,
    output logic                 item_valid,
    input  logic                 item_pop
);

    localparam int DEPTH = tfm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tfm_pkg::tfm_item_t q_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    tfm_pkg::tfm_item_t in_item;

    assign s_axis_tready = (32'(count_reg) != DEPTH) && !hold;
    assign push          = s_axis_tvalid && s_axis_tready;

    assign in_item.chr   = s_axis_tdata;
    assign in_item.term  = s_axis_tdata == tfm_pkg::CH_NUL;
    assign in_item.slash = s_axis_tdata == tfm_pkg::CH_SLASH;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (item_pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !item_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && item_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign item       = q_reg[rd_ptr_reg];
    assign item_valid = count_reg != '0;

endmodule

>>> hdl/tfm_back.sv
// Matching engine: walk the pattern for each queued byte and emit the verdict.
`timescale 1ns / 1ps

module tfm_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tfm_pkg::tfm_item_t              item,
    input  logic                            item_valid,
    output logic                            item_pop,
    input  tfm_pkg::tfm_cfg_status_t        status,
    output logic [tfm_pkg::REG_IDX_W-1:0]   rd_addr,
    input  logic [tfm_pkg::CFG_DATA_W-1:0]  rd_data,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata   // [0] topic_matches
);

    localparam int PW = tfm_pkg::POS_W;

    tfm_pkg::tfm_back_state_t state_reg, state_next;
    logic [PW-1:0]            pos_reg, pos_next;
    logic                     skip_reg, skip_next;
    logic                     known_reg, known_next;
    logic                     ans_reg, ans_next;
    logic [7:0]               chr_reg, chr_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_match_reg, out_match_next;

    logic                     out_free;
    logic                     take;
    logic                     pat_done;
    logic [7:0]               pat;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign take     = item_valid && !status.busy;
    assign pat_done = pos_reg >= status.eff_len;
    assign pat      = tfm_pkg::word_byte(rd_data, pos_reg[2:0]);
    assign rd_addr  = pos_reg[PW-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfm_pkg::BACK_IDLE;
            pos_reg       <= '0;
            skip_reg      <= 1'b0;
            known_reg     <= 1'b0;
            ans_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            skip_reg      <= skip_next;
            known_reg     <= known_next;
            ans_reg       <= ans_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chr_reg       <= chr_next;
        out_match_reg <= out_match_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tfm_pkg::BACK_IDLE:
            begin
                if (take && !item.term && !known_reg && !(skip_reg && !item.slash))
                    state_next = tfm_pkg::BACK_READ;
            end
            tfm_pkg::BACK_READ:
                state_next = tfm_pkg::BACK_EXEC;
            tfm_pkg::BACK_EXEC:
            begin
                // A plus that meets a slash steps on to the next pattern byte.
                if (!pat_done && pat == tfm_pkg::CH_PLUS && chr_reg == tfm_pkg::CH_SLASH)
                    state_next = tfm_pkg::BACK_READ;
                else
                    state_next = tfm_pkg::BACK_IDLE;
            end
            default:
                state_next = tfm_pkg::BACK_IDLE;
        endcase
    end

    always_comb
    begin
        pos_next       = pos_reg;
        skip_next      = skip_reg;
        known_next     = known_reg;
        ans_next       = ans_reg;
        chr_next       = chr_reg;
        out_match_next = out_match_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        item_pop       = 1'b0;
        case (state_reg)
            tfm_pkg::BACK_IDLE:
            begin
                if (take && item.term)
                begin
                    if (out_free)
                    begin
                        item_pop       = 1'b1;
                        out_valid_next = 1'b1;
                        if (status.eff_len == '0)
                            out_match_next = 1'b1;
                        else if (known_reg)
                            out_match_next = ans_reg;
                        else
                            out_match_next = pat_done;
                        pos_next   = '0;
                        skip_next  = 1'b0;
                        known_next = 1'b0;
                        ans_next   = 1'b0;
                    end
                end
                else if (take)
                begin
                    item_pop = 1'b1;
                    chr_next = item.chr;
                    if (!known_reg && skip_reg && item.slash)
                        skip_next = 1'b0;
                end
            end
            tfm_pkg::BACK_EXEC:
            begin
                if (pat_done || (pat != tfm_pkg::CH_HASH && pat != tfm_pkg::CH_PLUS
                                 && pat != chr_reg))
                begin
                    known_next = 1'b1;
                    ans_next   = 1'b0;
                    skip_next  = 1'b0;
                end
                else if (pat == tfm_pkg::CH_HASH)
                begin
                    known_next = 1'b1;
                    ans_next   = 1'b1;
                    skip_next  = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                    if (pat == tfm_pkg::CH_PLUS && chr_reg != tfm_pkg::CH_SLASH)
                        skip_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_match_reg};

endmodule

>>> hdl/topic_filter_matcher_core.sv
// Top level of the topic filter matcher: register port, front queue and engine.
`timescale 1ns / 1ps
// Usage:
//   Write pattern_length at byte address 0 and the pattern words at 8, 16 .. 48
//   over the APB-style port; reads return the stored values. Then stream the
//   topic one byte per word on s_axis; a zero byte ends the topic and yields one
//   word on m_axis whose bit 0 is the match flag. Other bytes yield nothing.
// Sequence:
//   A byte that needs a pattern compare passes through the engine as take,
//   pattern memory read and compare; each further plus wildcard crossed by a slash
//   repeats the read and compare. Terminators, bytes inside a plus level and bytes
//   after the verdict is settled need no pattern read. With the engine idle and
//   the queue empty, a terminator accepted on s_axis passes the queue register and
//   then the output register before m_axis_tvalid rises. Every register write
//   starts a scan for the pattern's end, a read and a check per pattern word up
//   to that end, during which s_axis is not ready.
// Reset:
//   Clears the length, the pattern, the queue and the per-topic state.
// Stalls:
//   A two-word queue decouples input from the engine; while m_axis is stalled
//   the verdict holds in the output register and later bytes fill the queue.
`include "topic_filter_matcher_core_defines.svh"

module topic_filter_matcher_core #(
    parameter int PATTERN_BYTES = tfm_pkg::PATTERN_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] topic_char
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [0] topic_matches
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tfm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [tfm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [tfm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    tfm_pkg::tfm_cfg_status_t       cfg_status;
    tfm_pkg::tfm_item_t             item;
    logic                           item_valid;
    logic                           item_pop;
    logic [tfm_pkg::REG_IDX_W-1:0]  back_addr;
    logic [tfm_pkg::CFG_DATA_W-1:0] pat_word;

    // Pattern store and the scan that finds the pattern's working length.
    tfm_cfg #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .back_addr (back_addr),
        .rd_data   (pat_word),
        .status    (cfg_status)
    );

    // Hold the input while the scan runs so no byte sees a stale length.
    tfm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .hold          (cfg_status.busy),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop)
    );

    tfm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop),
        .status        (cfg_status),
        .rd_addr       (back_addr),
        .rd_data       (pat_word),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `TFM_ASSERT_NOW(a_scan_holds_input, cfg_status.busy, !s_axis_tready, "input during scan")
    `TFM_ASSERT_NEXT(a_write_starts_scan, psel && penable && pwrite, cfg_status.busy, "no scan")
    `TFM_ASSERT_NOW(a_len_ok, !cfg_status.busy, cfg_status.eff_len <= 6'(PATTERN_BYTES), "length")

endmodule

>>> test/topic_filter_matcher_core_tb.sv
// Self-checking testbench for the topic filter matcher core.
`timescale 1ns / 1ps

module topic_filter_matcher_core_tb;
    import tfm_pkg::*;

    // Bench constants
    localparam int WORD_COUNT     = PATTERN_BYTES_DEF / WORD_BYTES;
    localparam int RANDOM_WORDS   = 1900;   // topic words in the random part
    localparam int SETTLE_CYCLES  = 16;     // quiet time after the last verdict
    localparam int LIMIT_CYCLES   = 600000;
    localparam int TOPIC_MAX      = 250;
    localparam int DIR_ROWS       = 30;

    // Index beyond the register map: a write there must change nothing.
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

    // One row of the directed table: either a register write or a topic word.
    typedef enum logic {
        ROW_BYTE,
        ROW_REG
    } row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [REG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  value;
        logic [7:0]             chr;
        logic                   typed;    // verdict given in the row itself
        logic                   verdict;
    } row_t;

    // Clock, reset and block ports
    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_tdata = 8'h00;
    logic                   m_axis_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    // Shadow of the filter registers and of the per-topic matching state
    logic [POS_W-1:0]       shadow_len = '0;
    logic [CFG_DATA_W-1:0]  shadow_word [WORD_COUNT];
    logic [POS_W-1:0]       cur_pos = '0;
    logic                   skipping = 1'b0;
    logic                   settled = 1'b0;
    logic                   settled_val = 1'b0;

    // Verdicts still owed by the block, oldest first
    logic                   expected_verdicts [$];

    // Scratch buffers for the filter and topic generators
    logic [7:0]             pat_buf [PATTERN_BYTES_DEF];
    int                     filt_n;
    logic [7:0]             topic_buf [TOPIC_MAX];
    int                     topic_n;

    // Idle rates in percent, set per phase of the run
    int                     tx_gap_pct = 6;
    int                     rx_stall_pct = 48;

    int                     fail_count = 0;
    int                     words_sent = 0;
    int                     topics_sent = 0;
    int                     verdicts_checked = 0;
    int                     filter_loads = 0;
    int                     readbacks = 0;
    int                     cycle_count = 0;

    // Directed table. Verdicts are typed in only where they are plain to see;
    // the remaining terminators take the predicted verdict.
    row_t dir_rows [DIR_ROWS] = '{
        // Accept-all filter after reset: every topic matches, the empty one too
        '{ROW_BYTE, REG_SPARE, 64'd0, "a", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "/", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, CH_NUL, 1'b1, 1'b1},
        '{ROW_BYTE, REG_SPARE, 64'd0, CH_NUL, 1'b1, 1'b1},
        // Filter "s/+/#"; junk above the six length bits must be dropped
        '{ROW_REG, REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFC5, CH_NUL, 1'b0, 1'b0},
        '{ROW_REG, REG_WORD0, 64'h0000_0023_2F2B_2F73, CH_NUL, 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "s", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "/", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "x", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "/", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "y", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, CH_NUL, 1'b0, 1'b0},
        // Topic ends while the filter still has bytes left
        '{ROW_BYTE, REG_SPARE, 64'd0, "s", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, CH_NUL, 1'b1, 1'b0},
        // Topic ends inside the plus level with the hash still waiting
        '{ROW_BYTE, REG_SPARE, 64'd0, "s", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "/", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "q", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, CH_NUL, 1'b1, 1'b0},
        // Literal mismatch on the first word
        '{ROW_BYTE, REG_SPARE, 64'd0, "t", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, CH_NUL, 1'b1, 1'b0},
        // Filter "ab": a longer topic must not match
        '{ROW_REG, REG_LENGTH, 64'd2, CH_NUL, 1'b0, 1'b0},
        '{ROW_REG, REG_WORD0, 64'h0000_0000_0000_6261, CH_NUL, 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "a", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "b", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "c", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, CH_NUL, 1'b1, 1'b0},
        // Write beyond the map, then show that "ab" still matches exactly
        '{ROW_REG, REG_SPARE, 64'h0000_0000_0000_2B23, CH_NUL, 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "a", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, "b", 1'b0, 1'b0},
        '{ROW_BYTE, REG_SPARE, 64'd0, CH_NUL, 1'b1, 1'b1}
    };

    topic_filter_matcher_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),       // [7:0] topic_char
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),  // [0] topic_matches, [7:1] zero
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Match predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] filter_byte(input int unsigned i);
        return shadow_word[i / WORD_BYTES][8 * (i % WORD_BYTES) +: 8];
    endfunction

    // Used filter length: clamp to the store size, then cut at the first NUL.
    function automatic int unsigned filter_span();
        int unsigned lim;
        int unsigned i;
        lim = (shadow_len > PATTERN_BYTES_DEF) ? PATTERN_BYTES_DEF : shadow_len;
        for (i = 0; i < lim; i++)
            if (filter_byte(i) == CH_NUL)
                return i;
        return lim;
    endfunction

    function automatic void settle_verdict(input logic v);
        settled     = 1'b1;
        settled_val = v;
        skipping    = 1'b0;
    endfunction

    // Advance the matcher by one topic word; return 1 when a verdict is due.
    function automatic bit match_step(input logic [7:0] c, output logic hit);
        int unsigned span;
        logic [7:0]  p;
        bit          done;
        span = filter_span();
        hit  = 1'b0;
        if (c == CH_NUL)
        begin
            if (span == 0)
                hit = 1'b1;
            else if (settled)
                hit = settled_val;
            else
                hit = (cur_pos >= span);
            cur_pos     = '0;
            skipping    = 1'b0;
            settled     = 1'b0;
            settled_val = 1'b0;
            return 1'b1;
        end
        if (settled)
            return 1'b0;
        if (skipping)
        begin
            if (c != CH_SLASH)
                return 1'b0;
            skipping = 1'b0;
        end
        // Each pass either settles, stops, or steps over a plus.
        done = 1'b0;
        while (!done)
        begin
            if (cur_pos >= span)
            begin
                settle_verdict(1'b0);
                done = 1'b1;
            end
            else
            begin
                p = filter_byte(cur_pos);
                if (p == CH_HASH)
                begin
                    settle_verdict(1'b1);
                    done = 1'b1;
                end
                else if (p == CH_PLUS)
                begin
                    cur_pos = cur_pos + 1'b1;
                    if (c != CH_SLASH)
                    begin
                        skipping = 1'b1;
                        done     = 1'b1;
                    end
                end
                else if (p != c)
                begin
                    settle_verdict(1'b0);
                    done = 1'b1;
                end
                else
                begin
                    cur_pos = cur_pos + 1'b1;
                    done    = 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // Setup phase, access phase, then idle with psel low so back-to-back
    // transfers never drive psel twice in the same step.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == REG_LENGTH)
            shadow_len = value[POS_W-1:0];
        else if (idx >= REG_WORD0 && idx < REG_WORD0 + WORD_COUNT)
            shadow_word[idx - REG_WORD0] = value;
    endtask

    task automatic reg_read(input logic [REG_IDX_W-1:0] idx,
                            output logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        value   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Read every register back and compare with the shadow copy.
    task automatic check_regs();
        logic [CFG_DATA_W-1:0] got;
        logic [CFG_DATA_W-1:0] want;
        int                    k;
        for (k = 0; k <= WORD_COUNT; k++)
        begin
            reg_read(REG_LENGTH + REG_IDX_W'(k), got);
            if (k == 0)
                want = {{(CFG_DATA_W - POS_W){1'b0}}, shadow_len};
            else
                want = shadow_word[k - 1];
            readbacks++;
            if (got !== want)
            begin
                $display("%0t: register %0d readback mismatch: expected %h, actual %h",
                         $time, k, want, got);
                fail_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Topic stream
    // ------------------------------------------------------------------

    // Offer one word; gaps before it follow the current sender idle rate.
    task automatic send_word(input logic [7:0] c, input logic typed,
                             input logic typed_val);
        logic hit;
        while ($urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_axis_tready);
        // Word taken at this edge: advance the predictor now.
        if (match_step(c, hit))
        begin
            expected_verdicts.push_back(typed ? typed_val : hit);
            topics_sent++;
        end
        words_sent++;
    endtask

    // Drop valid, drain all verdicts, then let the engine go quiet.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus generators
    // ------------------------------------------------------------------

    function automatic logic [7:0] level_char();
        logic [7:0] c;
        if ($urandom_range(99) < 70)
            return 8'h61 + 8'($urandom_range(2));
        c = 8'($urandom_range(1, 255));
        if (c == CH_SLASH)
            c = 8'hAF;
        return c;
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(5))
            0:       return "a";
            1:       return "b";
            2:       return CH_SLASH;
            3:       return CH_PLUS;
            4:       return CH_HASH;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic void push_filter(input logic [7:0] b);
        if (filt_n < PATTERN_BYTES_DEF)
        begin
            pat_buf[filt_n] = b;
            filt_n++;
        end
    endfunction

    function automatic void push_topic(input logic [7:0] b);
        if (topic_n < TOPIC_MAX)
        begin
            topic_buf[topic_n] = b;
            topic_n++;
        end
    endfunction

    // Fill pat_buf with a filter: mostly well-formed levels, some noise,
    // some that fill the whole store.
    function automatic void build_filter();
        int style;
        int levels;
        int k;
        int j;
        int r;
        for (k = 0; k < PATTERN_BYTES_DEF; k++)
            pat_buf[k] = CH_NUL;
        filt_n = 0;
        style  = $urandom_range(99);
        if (style < 60)
        begin
            if ($urandom_range(99) < 10)
                push_filter(CH_SLASH);
            levels = $urandom_range(1, 6);
            for (k = 0; k < levels; k++)
            begin
                if (k > 0)
                    push_filter(CH_SLASH);
                r = $urandom_range(99);
                if (k == levels - 1 && r < 20)
                    push_filter(CH_HASH);
                else if (r < 40)
                    push_filter(CH_PLUS);
                else if (r < 46)
                begin
                    push_filter(CH_PLUS);
                    push_filter(CH_PLUS);
                end
                else
                    for (j = $urandom_range(1, 5); j > 0; j--)
                        push_filter(level_char());
            end
        end
        else if (style < 80)
        begin
            for (j = $urandom_range(1, 16); j > 0; j--)
                push_filter(($urandom_range(99) < 5) ? CH_NUL : noise_char());
        end
        else if (style < 90)
        begin
            // Chain of plus levels across the whole store
            while (filt_n < PATTERN_BYTES_DEF)
            begin
                push_filter(CH_PLUS);
                push_filter(CH_SLASH);
            end
            if ($urandom_range(1))
                pat_buf[PATTERN_BYTES_DEF - 1] = CH_HASH;
        end
        else
        begin
            while (filt_n < PATTERN_BYTES_DEF)
            begin
                if ($urandom_range(3) == 0)
                    push_filter(CH_PLUS);
                else
                    for (j = $urandom_range(1, 3); j > 0; j--)
                        push_filter(level_char());
                push_filter(CH_SLASH);
            end
        end
        // Sometimes leave junk past the filter's end
        if ($urandom_range(99) < 25)
            for (k = filt_n; k < PATTERN_BYTES_DEF; k++)
                pat_buf[k] = 8'($urandom_range(255));
    endfunction

    // Build a topic: mostly one that follows the active filter, then
    // perhaps broken; the rest is noise.
    function automatic void build_topic();
        int unsigned span;
        int unsigned i;
        logic [7:0]  p;
        bit          stop;
        int          j;
        int          r;
        topic_n = 0;
        if ($urandom_range(99) < 75)
        begin
            span = filter_span();
            stop = 1'b0;
            for (i = 0; i < span && !stop; i++)
            begin
                p = filter_byte(i);
                if (p == CH_HASH)
                begin
                    for (j = $urandom_range(0, 6); j > 0; j--)
                        push_topic(noise_char());
                    stop = 1'b1;
                end
                else if (p == CH_PLUS)
                    for (j = $urandom_range(0, 4); j > 0; j--)
                        push_topic(level_char());
                else
                    push_topic(p);
            end
            r = $urandom_range(99);
            if (r < 10 && topic_n > 0)
                topic_n = $urandom_range(0, topic_n - 1);
            else if (r < 20 && topic_n > 0)
                topic_buf[$urandom_range(0, topic_n - 1)] = noise_char();
            else if (r < 28)
                for (j = $urandom_range(1, 3); j > 0; j--)
                    push_topic(noise_char());
        end
        else
        begin
            for (j = $urandom_range(0, 20); j > 0; j--)
                push_topic(noise_char());
        end
    endfunction

    // Load a fresh filter and length, with the extremes weighted in.
    task automatic load_filter();
        logic [CFG_DATA_W-1:0] w;
        int unsigned           len_sel;
        int                    r;
        int                    k;
        int                    b;
        build_filter();
        r = $urandom_range(99);
        if (r < 60)
            len_sel = filt_n;
        else if (r < 70)
            len_sel = 0;
        else if (r < 80)
            len_sel = 63;
        else if (r < 90)
            len_sel = PATTERN_BYTES_DEF;
        else
            len_sel = $urandom_range(0, 63);
        for (k = 0; k < WORD_COUNT; k++)
        begin
            for (b = 0; b < WORD_BYTES; b++)
                w[8 * b +: 8] = pat_buf[k * WORD_BYTES + b];
            reg_write(REG_WORD0 + REG_IDX_W'(k), w);
        end
        // Random upper bits on the length word; only the low six count.
        w         = {$urandom(), $urandom()};
        w[POS_W-1:0] = len_sel[POS_W-1:0];
        reg_write(REG_LENGTH, w);
        if ($urandom_range(99) < 20)
            reg_write(REG_SPARE, {$urandom(), $urandom()});
        filter_loads++;
        check_regs();
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // Stall the verdict stream at the current receiver rate.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_stall_pct);

    // Compare each verdict taken with the oldest one owed.
    always @(posedge clk)
    begin : verdict_check
        logic [7:0] want;
        if (rst_n && m_axis_tvalid && m_tready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: verdict with none owed: expected nothing, actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = {7'b0, expected_verdicts.pop_front()};
                verdicts_checked++;
                if (m_axis_tdata !== want)
                begin
                    $display("%0t: verdict mismatch: expected %h, actual %h",
                             $time, want, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Hard stop on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d verdicts owed", $time,
                     expected_verdicts.size());
            $display("FAIL topic_filter_matcher_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_seq
        int mode;
        int mode_start;
        int r;
        int j;
        for (j = 0; j < WORD_COUNT; j++)
            shadow_word[j] = '0;

        // Hold reset, then release on a clock edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under light sender idling, heavy receiver stalls
        tx_gap_pct   = 6;
        rx_stall_pct = 48;
        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].kind == ROW_REG)
            begin
                wait_idle();
                reg_write(dir_rows[r].idx, dir_rows[r].value);
            end
            else
                send_word(dir_rows[r].chr, dir_rows[r].typed, dir_rows[r].verdict);
        end

        // Random part in three idle modes: sender light, receiver light, none
        for (mode = 0; mode < 3; mode++)
        begin
            tx_gap_pct   = (mode == 0) ? 6 : (mode == 1) ? 48 : 0;
            rx_stall_pct = (mode == 0) ? 48 : (mode == 1) ? 6 : 0;
            mode_start   = words_sent;
            while (words_sent - mode_start < RANDOM_WORDS / 3)
            begin
                wait_idle();
                load_filter();
                for (r = $urandom_range(4, 12); r > 0; r--)
                begin
                    build_topic();
                    for (j = 0; j < topic_n; j++)
                        send_word(topic_buf[j], 1'b0, 1'b0);
                    send_word(CH_NUL, 1'b0, 1'b0);
                end
            end
        end

        // Drain every verdict and give the engine time to fall silent
        wait_idle();

        $display("Streamed %0d topic words in %0d topics under %0d filter loads",
                 words_sent, topics_sent, filter_loads);
        $display("Compared %0d verdicts and %0d register readbacks",
                 verdicts_checked, readbacks);
        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("PASS topic_filter_matcher_core");
        else
            $display("FAIL topic_filter_matcher_core");
        $finish;
    end

endmodule
